/* hw/rtl/tsms_pkg.sv */
// Package for the tile shift median smoother.
// Holds the request types, the store word, the window control struct and shared constants.
// Depends on nothing.
package tsms_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int LIM_W           = 9;
  localparam int REG_W           = 7;
  localparam int CNT_W           = 4;
  localparam int WIN_N           = 9;
  localparam int SHIFT_W         = 16;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;
  localparam logic REG_COLUMNS  = 1'b0;
  localparam logic REG_ROWS     = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [5:0]                column;
    logic [5:0]                row;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
  } in_req_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] median_x;
    logic signed [SHIFT_W-1:0] median_y;
    logic [CNT_W-1:0]          window_count;
    logic                      status;
  } out_req_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] x;
    logic signed [SHIFT_W-1:0] y;
  } vec_t;

  typedef struct packed {
    logic             clear;
    logic             capture;
    logic             step;
    logic [CNT_W-1:0] ci;
  } sel_ctrl_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] lo_x;
    logic signed [SHIFT_W-1:0] hi_x;
    logic signed [SHIFT_W-1:0] lo_y;
    logic signed [SHIFT_W-1:0] hi_y;
  } med_t;

endpackage

/* hw/rtl/tile_shift_median_smoother.sv */
// Tile shift median smoother: a store of per-tile Q8.8 shift vectors with a 3x3 median query.
// A load or an out-of-grid request goes from idle to the done state, which registers its
// result; a query first walks all nine window positions through the single memory port,
// then takes a drain step, one rank step per window entry and the output step. A result
// that waits on out_ready holds the next result in the done state, where no request is
// taken. Depends on tsms_pkg, tsms_ram and tsms_select.
module tile_shift_median_smoother #(
  parameter int MAX_COLUMNS = tsms_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tsms_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsms_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsms_pkg::out_req_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = tsms_pkg::LIM_W;

  typedef enum logic [1:0] {ST_IDLE, ST_GATHER, ST_RANK, ST_DONE} state_t;

  function automatic logic [1:0] tap_row(input logic [tsms_pkg::CNT_W-1:0] pos);
    logic [1:0] r;
    case (pos)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [tsms_pkg::CNT_W-1:0] pos);
    logic [1:0] c;
    case (pos)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  state_t                     state_r;
  logic [5:0]                 row_r, col_r;
  logic [tsms_pkg::CNT_W-1:0] pos_r, ci_r;
  logic                       rd_pend_r;
  logic                       status_r;
  logic                       out_valid_r;
  tsms_pkg::out_req_t         out_data_r;
  logic [tsms_pkg::REG_W-1:0] cols_r, rows_r;

  logic [LW-1:0]              cols_eff, rows_eff, nb_row, nb_col;
  logic                       accept, in_grid, nb_ok;
  logic [AW-1:0]              load_addr, nb_addr;
  logic                       ram_en, ram_we;
  logic [AW-1:0]              ram_addr;
  tsms_pkg::vec_t             ram_wdata, ram_rdata;
  tsms_pkg::sel_ctrl_t        sel_ctrl;
  logic [tsms_pkg::CNT_W-1:0] sel_count;
  tsms_pkg::med_t             sel_med;
  logic [tsms_pkg::SHIFT_W:0] sum_x, sum_y;
  logic                       cfg_wr;

  assign cols_eff = (LW'(cols_r) > LW'(MAX_COLUMNS)) ? LW'(MAX_COLUMNS) : LW'(cols_r);
  assign rows_eff = (LW'(rows_r) > LW'(MAX_ROWS))    ? LW'(MAX_ROWS)    : LW'(rows_r);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_grid  = (LW'(in_data.column) < cols_eff) && (LW'(in_data.row) < rows_eff);
  assign load_addr = AW'(32'(in_data.row) * MAX_COLUMNS + 32'(in_data.column));

  assign nb_row  = LW'(row_r) + LW'(tap_row(pos_r)) - LW'(1);
  assign nb_col  = LW'(col_r) + LW'(tap_col(pos_r)) - LW'(1);
  assign nb_ok   = (pos_r < tsms_pkg::CNT_W'(tsms_pkg::WIN_N)) &&
                   (nb_row < rows_eff) && (nb_col < cols_eff);
  assign nb_addr = AW'(32'(nb_row) * MAX_COLUMNS + 32'(nb_col));

  always_comb begin
    ram_we      = (state_r == ST_IDLE);
    ram_en      = (accept && in_grid && (in_data.mode == tsms_pkg::MODE_LOAD)) ||
                  ((state_r == ST_GATHER) && nb_ok);
    ram_addr    = (state_r == ST_IDLE) ? load_addr : nb_addr;
    ram_wdata.x = in_data.shift_x;
    ram_wdata.y = in_data.shift_y;
  end

  always_comb begin
    sel_ctrl.clear   = accept;
    sel_ctrl.capture = (state_r == ST_GATHER) && rd_pend_r;
    sel_ctrl.step    = (state_r == ST_RANK);
    sel_ctrl.ci      = ci_r;
  end

  tsms_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    ($bits(tsms_pkg::vec_t))
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tsms_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (sel_ctrl),
    .cap_data (ram_rdata),
    .count    (sel_count),
    .med      (sel_med)
  );

  assign sum_x = {sel_med.lo_x[tsms_pkg::SHIFT_W-1], sel_med.lo_x} +
                 {sel_med.hi_x[tsms_pkg::SHIFT_W-1], sel_med.hi_x};
  assign sum_y = {sel_med.lo_y[tsms_pkg::SHIFT_W-1], sel_med.lo_y} +
                 {sel_med.hi_y[tsms_pkg::SHIFT_W-1], sel_med.hi_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      ci_r        <= '0;
      rd_pend_r   <= 1'b0;
      status_r    <= tsms_pkg::STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            row_r     <= in_data.row;
            col_r     <= in_data.column;
            pos_r     <= '0;
            rd_pend_r <= 1'b0;
            status_r  <= in_grid ? tsms_pkg::STATUS_OK : tsms_pkg::STATUS_RANGE;
            if (in_grid && (in_data.mode == tsms_pkg::MODE_QUERY)) begin
              state_r <= ST_GATHER;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_GATHER: begin
          rd_pend_r <= nb_ok;
          pos_r     <= pos_r + tsms_pkg::CNT_W'(1);
          if (pos_r == tsms_pkg::CNT_W'(tsms_pkg::WIN_N)) begin
            ci_r    <= '0;
            state_r <= ST_RANK;
          end
        end
        ST_RANK: begin
          if (ci_r == sel_count - tsms_pkg::CNT_W'(1)) begin
            state_r <= ST_DONE;
          end else begin
            ci_r <= ci_r + tsms_pkg::CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.median_x     <= sum_x[tsms_pkg::SHIFT_W:1];
            out_data_r.median_y     <= sum_y[tsms_pkg::SHIFT_W:1];
            out_data_r.window_count <= sel_count;
            out_data_r.status       <= status_r;
            state_r                 <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= tsms_pkg::REG_W'(1);
      rows_r <= tsms_pkg::REG_W'(1);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == tsms_pkg::REG_COLUMNS) begin
        cols_r <= cfg_pwdata[tsms_pkg::REG_W-1:0];
      end else begin
        rows_r <= cfg_pwdata[tsms_pkg::REG_W-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      tsms_pkg::REG_COLUMNS: cfg_prdata = 32'(cols_r);
      tsms_pkg::REG_ROWS:    cfg_prdata = 32'(rows_r);
      default:               cfg_prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/tsms_ram.sv */
// Single-port synchronous memory for the tile shift store.
// Read data is registered. No package dependency.
module tsms_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tsms_select.sv */
// Window bank and rank selector of the tile shift median smoother.
// Collects up to nine neighbor vectors and finds the two middle values per axis,
// one candidate per cycle while the step control is set. Depends on tsms_pkg.
module tsms_select (
  input  logic               clk,
  input  logic               rst_n,
  input  tsms_pkg::sel_ctrl_t ctrl,
  input  tsms_pkg::vec_t     cap_data,
  output logic [tsms_pkg::CNT_W-1:0] count,
  output tsms_pkg::med_t     med
);

  tsms_pkg::vec_t             bank_r [tsms_pkg::WIN_N];
  logic [tsms_pkg::CNT_W-1:0] cnt_r;
  tsms_pkg::med_t             med_r;

  tsms_pkg::vec_t             cand;
  logic [tsms_pkg::CNT_W-1:0] lt_x, le_x, lt_y, le_y;
  logic [tsms_pkg::CNT_W-1:0] k_lo, k_hi;
  logic                       hit_lo_x, hit_hi_x, hit_lo_y, hit_hi_y;

  always_comb begin
    cand = bank_r[ctrl.ci];
    lt_x = '0;
    le_x = '0;
    lt_y = '0;
    le_y = '0;
    for (int j = 0; j < tsms_pkg::WIN_N; j++) begin
      if (tsms_pkg::CNT_W'(j) < cnt_r) begin
        lt_x = lt_x + tsms_pkg::CNT_W'($signed(bank_r[j].x) <  $signed(cand.x));
        le_x = le_x + tsms_pkg::CNT_W'($signed(bank_r[j].x) <= $signed(cand.x));
        lt_y = lt_y + tsms_pkg::CNT_W'($signed(bank_r[j].y) <  $signed(cand.y));
        le_y = le_y + tsms_pkg::CNT_W'($signed(bank_r[j].y) <= $signed(cand.y));
      end
    end
    k_hi = cnt_r >> 1;
    k_lo = cnt_r[0] ? k_hi : k_hi - tsms_pkg::CNT_W'(1);
    hit_lo_x = (lt_x <= k_lo) && (k_lo < le_x);
    hit_hi_x = (lt_x <= k_hi) && (k_hi < le_x);
    hit_lo_y = (lt_y <= k_lo) && (k_lo < le_y);
    hit_hi_y = (lt_y <= k_hi) && (k_hi < le_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      med_r <= '0;
    end else if (ctrl.clear) begin
      cnt_r <= '0;
      med_r <= '0;
    end else begin
      if (ctrl.capture) begin
        bank_r[cnt_r] <= cap_data;
        cnt_r         <= cnt_r + tsms_pkg::CNT_W'(1);
      end
      if (ctrl.step) begin
        if (hit_lo_x) begin
          med_r.lo_x <= cand.x;
        end
        if (hit_hi_x) begin
          med_r.hi_x <= cand.x;
        end
        if (hit_lo_y) begin
          med_r.lo_y <= cand.y;
        end
        if (hit_hi_y) begin
          med_r.hi_y <= cand.y;
        end
      end
    end
  end

  assign count = cnt_r;
  assign med   = med_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tsms_pkg::CNT_W'(tsms_pkg::WIN_N))
    else $error("window bank holds more than nine entries");

  a_cap_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.capture |-> cnt_r < tsms_pkg::CNT_W'(tsms_pkg::WIN_N))
    else $error("capture into a full window bank");

  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |-> (ctrl.ci < cnt_r) && !ctrl.capture)
    else $error("rank step on an empty bank slot or during capture");

endmodule
